>>> src/k_way_sorted_merge_defines.svh
// Assertion macros shared by the k-way sorted merge RTL.
`ifndef K_WAY_SORTED_MERGE_DEFINES_SVH
`define K_WAY_SORTED_MERGE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock and muted during reset.
`define KWM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock and muted during reset.
`define KWM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/kwm_pkg.sv
// Package with the types, constants and helper functions of the k-way sorted merge.
package kwm_pkg;

    localparam int MAX_LISTS   = 8;
    localparam int LANE_W      = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
    localparam int TREE_LEAVES = 1 << LANE_W;
    localparam int CNT_W       = $clog2(MAX_LISTS + 1);
    localparam int VAL_W       = 32;
    localparam int SRC_W       = 3;
    localparam int CFG_W       = 4;

    localparam logic [CFG_W-1:0] LISTS_USED_RESET = 4'd8;

    typedef logic [LANE_W-1:0] t_lane;
    typedef logic [CNT_W-1:0]  t_count;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    present;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] merged_value;
        logic [SRC_W-1:0]        source_lane;
        logic                    done_res;
    } t_out_item;

    // Winner of the minimum search over the lane heads.
    typedef struct packed {
        logic                    found;
        t_lane                   lane;
        logic signed [VAL_W-1:0] value;
    } t_min_sel;

    // Number of lanes that take part: zero counts as one, large values saturate.
    function automatic t_count eff_used(input logic [CFG_W-1:0] lists_used);
        t_count res;
        if (lists_used == '0) begin
            res = t_count'(1);
        end else if (32'(lists_used) > 32'(MAX_LISTS)) begin
            res = t_count'(MAX_LISTS);
        end else begin
            res = t_count'(lists_used);
        end
        return res;
    endfunction

    // Lane number as reported on the result, kept to its low three bits.
    function automatic logic [SRC_W-1:0] to_src(input t_lane lane);
        return SRC_W'({{SRC_W{1'b0}}, lane});
    endfunction

endpackage

>>> src/kwm_in_stage.sv
// Input register stage that holds one accepted beat until the merge logic takes it.
module kwm_in_stage
    import kwm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_data,
    output logic     o_item_valid,
    output t_in_item o_item,
    input  logic     i_take
);

    logic     r_valid;
    t_in_item r_item;

    // The stage refills in the same cycle that its beat moves on.
    assign o_in_ready   = !r_valid || i_take;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= i_in_data;
        end
    end

endmodule

>>> src/kwm_min_tree.sv
// Comparator tree that finds the smallest valid lane head, lowest lane on ties.
module kwm_min_tree
    import kwm_pkg::*;
(
    input  logic [MAX_LISTS-1:0][VAL_W-1:0] i_head_value,
    input  logic [MAX_LISTS-1:0]            i_head_valid,
    output t_min_sel                        o_sel
);

    logic signed [VAL_W-1:0] node_val [2*TREE_LEAVES];
    logic                    node_vld [2*TREE_LEAVES];
    t_lane                   node_lane[2*TREE_LEAVES];

    // Heap layout: leaves sit at TREE_LEAVES + lane, node k merges 2k and 2k+1.
    always_comb begin
        logic take_left;
        for (int k = 0; k < 2*TREE_LEAVES; k++) begin
            node_val[k]  = '0;
            node_vld[k]  = 1'b0;
            node_lane[k] = '0;
        end
        for (int i = 0; i < TREE_LEAVES; i++) begin
            node_lane[TREE_LEAVES + i] = LANE_W'(i);
            if (i < MAX_LISTS) begin
                node_val[TREE_LEAVES + i] = $signed(i_head_value[i]);
                node_vld[TREE_LEAVES + i] = i_head_valid[i];
            end
        end
        for (int k = TREE_LEAVES - 1; k >= 1; k--) begin
            // The left child always holds the lower lanes, so it wins a tie.
            take_left = node_vld[2*k] &&
                        (!node_vld[2*k+1] || (node_val[2*k] <= node_val[2*k+1]));
            if (take_left) begin
                node_val[k]  = node_val[2*k];
                node_vld[k]  = node_vld[2*k];
                node_lane[k] = node_lane[2*k];
            end else begin
                node_val[k]  = node_val[2*k+1];
                node_vld[k]  = node_vld[2*k+1];
                node_lane[k] = node_lane[2*k+1];
            end
        end
    end

    assign o_sel.found = node_vld[1];
    assign o_sel.lane  = node_lane[1];
    assign o_sel.value = node_val[1];

endmodule

>>> src/k_way_sorted_merge.sv
// Top level of the k-way sorted merge: lane heads, phase control and result register.
//
// Merges up to eight ascending signed 32-bit streams into one ascending
// stream. After a reset, or after a done result, the block is loading: the
// first lists_used input beats give the heads of lanes 0, 1, ... in order
// (present low marks a lane empty), and the last of them yields the smallest
// head with its lane. From then on each input beat refills the lane named by
// the previous result's source_lane (present low marks it exhausted) and
// yields the next smallest head; ties go to the lowest lane. When no lane
// holds a head, a result with done_res high and zero value and lane is given
// and the block starts loading again. lists_used of zero acts as one, and
// values above eight act as eight; it is written through the configuration
// channel, which is always ready, and should only change while no beat is in
// flight. A change in the middle of a merge takes effect at the next load.
// Timing: an accepted beat waits in the input register until the result
// register has room for its result; the head update and an eight-way
// comparator tree then work out any result that it yields, and that result
// lands in the output register as the beat is taken. One beat is accepted
// every cycle as long as results are taken. While a finished result waits
// in the output register, the input register still takes one more beat,
// and then o_in_ready stays low until the waiting result is taken.
`include "k_way_sorted_merge_defines.svh"

module k_way_sorted_merge
    import kwm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Input beats
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_data,
    // Result beats
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_data,
    // Configuration: lists_used
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    // Configuration register.
    logic [CFG_W-1:0] r_lists_used;

    // Lane heads and merge state.
    logic [MAX_LISTS-1:0][VAL_W-1:0] r_head_value;
    logic [MAX_LISTS-1:0][VAL_W-1:0] n_head_value;
    logic [MAX_LISTS-1:0]            r_head_valid;
    logic [MAX_LISTS-1:0]            n_head_valid;
    t_count                          r_loaded;
    t_count                          n_loaded;
    t_lane                           r_served;
    t_lane                           n_served;
    logic                            r_merging;
    logic                            n_merging;

    // Result register.
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    // Work stage signals.
    logic     item_valid;
    t_in_item item;
    logic     take;
    logic     last_load;
    logic     has_result;
    t_lane    wr_lane;
    t_min_sel sel;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lists_used <= LISTS_USED_RESET;
        end else if (i_cfg_valid) begin
            r_lists_used <= i_cfg_data;
        end
    end

    kwm_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_take       (take)
    );

    // The held beat is worked on whenever the result register has room for
    // its result, or is being emptied this cycle.
    assign take = item_valid && (!r_out_valid || i_out_ready);

    // During loading the lane is the load position; during merging it is
    // the lane that the last result came from.
    assign wr_lane   = r_merging ? r_served : r_loaded[LANE_W-1:0];
    assign last_load = t_count'(r_loaded + t_count'(1)) >= eff_used(r_lists_used);
    assign has_result = take && (r_merging || last_load);

    // Head update for the beat being worked on. A lane marked absent keeps its
    // old value bits, which are never looked at while the lane is invalid.
    always_comb begin
        n_head_value = r_head_value;
        n_head_valid = r_head_valid;
        if (take) begin
            if (item.present) begin
                n_head_value[wr_lane] = item.value;
            end
            n_head_valid[wr_lane] = item.present;
        end
    end

    // The minimum is taken over the heads as they stand after this beat.
    kwm_min_tree u_min_tree (
        .i_head_value (n_head_value),
        .i_head_valid (n_head_valid),
        .o_sel        (sel)
    );

    // Phase control and the result for this beat.
    always_comb begin
        n_loaded  = r_loaded;
        n_served  = r_served;
        n_merging = r_merging;
        n_out     = '0;
        if (take && !r_merging && !last_load) begin
            n_loaded = t_count'(r_loaded + t_count'(1));
        end
        if (has_result) begin
            n_loaded = '0;
            if (sel.found) begin
                n_served           = sel.lane;
                n_merging          = 1'b1;
                n_out.merged_value = sel.value;
                n_out.source_lane  = to_src(sel.lane);
                n_out.done_res     = 1'b0;
            end else begin
                // Every lane is exhausted, so the valid flags are already clear.
                n_served       = '0;
                n_merging      = 1'b0;
                n_out.done_res = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_head_value <= n_head_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= '0;
            r_loaded     <= '0;
            r_served     <= '0;
            r_merging    <= 1'b0;
        end else begin
            r_head_valid <= n_head_valid;
            r_loaded     <= n_loaded;
            r_served     <= n_served;
            r_merging    <= n_merging;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (has_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (has_result) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `KWM_ASSERT_NOW(a_done_payload_zero, o_out_valid && o_out_data.done_res, o_out_data.merged_value == '0 && o_out_data.source_lane == '0, "done result carries a value or lane")
    `KWM_ASSERT_NEXT(a_done_back_to_load, has_result && !sel.found, !r_merging && r_head_valid == '0 && r_loaded == '0 && r_served == '0, "done result did not return to loading")
    `KWM_ASSERT_NOW(a_served_lane_valid, r_merging, r_head_valid[r_served], "served lane has no valid head while merging")
    `KWM_ASSERT_NOW(a_loaded_in_range, !r_merging, 32'(r_loaded) < 32'(MAX_LISTS), "load position ran past the last lane")

endmodule
